@@ rtl/sogi_single_phase_pll_core_defines.svh @@
// Assertion macros for the SOGI PLL core.
`ifndef SOGI_SINGLE_PHASE_PLL_CORE_DEFINES_SVH
`define SOGI_SINGLE_PHASE_PLL_CORE_DEFINES_SVH
// Property that must hold at every rising clock edge outside reset.
`define SPLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define SPLL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

@@ rtl/spll_pkg.sv @@
// Package: widths, sequencer codes, sine table and helpers for the SOGI PLL.
package spll_pkg;
    localparam int PHASE_TABLE_BITS = 10;
    localparam int QUARTER_SIZE = 1 << (PHASE_TABLE_BITS - 2);
    localparam int QBITS = PHASE_TABLE_BITS - 2;
    localparam int REG_COUNT = 8;
    localparam int IDX_W = 3;
    localparam int DIGIT_W = 4;
    localparam int MUL_STEPS = 64 / DIGIT_W;
    localparam int STEP_W = 5;

    localparam logic [IDX_W-1:0] REG_DIRECT = 3'd0;
    localparam logic [IDX_W-1:0] REG_FB1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_FB2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUAD = 3'd3;
    localparam logic [IDX_W-1:0] REG_LG_NOW = 3'd4;
    localparam logic [IDX_W-1:0] REG_LG_PRIOR = 3'd5;
    localparam logic [IDX_W-1:0] REG_NOMINAL = 3'd6;
    localparam logic [IDX_W-1:0] REG_STEP = 3'd7;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -36'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic [15:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int div [5];
        div = '{110, 72, 42, 20, 6};
        x = (64'(k) * 64'd1686629713) >> QBITS;
        x2 = (x * x) >> 30;
        t = 64'd1073741824;
        for (int i = 0; i < 5; i++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'(div[i]);
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
            s = 64'd32767;
        return s[15:0];
    endfunction

    // Pack the first quarter of the wave, one 16-bit entry per point.
    function automatic logic [16*QUARTER_SIZE-1:0] build_quarter_table();
        logic [16*QUARTER_SIZE-1:0] tbl;
        tbl = '0;
        for (int k = 0; k < QUARTER_SIZE; k++)
            tbl[16*k +: 16] = quarter_sine(k);
        return tbl;
    endfunction

    localparam logic [16*QUARTER_SIZE-1:0] QUARTER_TABLE = build_quarter_table();
    // value at the quarter-turn point itself
    localparam logic [15:0] QUARTER_PEAK = quarter_sine(QUARTER_SIZE);

    function automatic logic signed [15:0] table_sine(input logic [PHASE_TABLE_BITS-1:0] idx);
        logic [QBITS-1:0] off;
        logic [QBITS-1:0] mirror;
        logic [15:0] v;
        off = idx[QBITS-1:0];
        // distance back from the end of the quarter
        mirror = -off;
        if (idx[QBITS] && (off == '0))
            v = QUARTER_PEAK;
        else if (idx[QBITS])
            v = QUARTER_TABLE[16*int'(mirror) +: 16];
        else
            v = QUARTER_TABLE[16*int'(off) +: 16];
        return idx[QBITS+1] ? -$signed(v) : $signed(v);
    endfunction
endpackage

@@ rtl/spll_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface spll_in_if
    import spll_pkg::*;
    (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface spll_out_if
    import spll_pkg::*;
    (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] frequency;
    logic [31:0]        phase_angle;
    logic signed [15:0] sine_out;
    logic signed [15:0] cosine_out;
    logic signed [31:0] q_error;
    logic signed [31:0] d_component;
    modport source (output valid, output frequency, output phase_angle, output sine_out,
                    output cosine_out, output q_error, output d_component, input ready);
    modport sink (input valid, input frequency, input phase_angle, input sine_out,
                  input cosine_out, input q_error, input d_component, output ready);
endinterface

@@ rtl/spll_mul.sv @@
// Digit-serial signed 32x32 multiplier, four multiplier bits per cycle.
module spll_mul
    import spll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       mcand_reg, mcand_next;
    logic [63:0]       mplier_reg, mplier_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next = '0;
            mcand_next = 64'($signed(req.a));
            mplier_next = 64'($signed(req.b));
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add one digit's partial product, modulo 2^64 gives the signed result
            acc_next = acc_reg + mcand_reg * 64'(mplier_reg[DIGIT_W-1:0]);
            mcand_next = mcand_reg << DIGIT_W;
            mplier_next = mplier_reg >> DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule

@@ rtl/sogi_single_phase_pll_core.sv @@
// Top level of the SOGI single-phase PLL core.
// One sample in, one result out. Every product (six filter products, four Park
// products, two loop products, one phase-increment product: 13 in all) goes in
// turn through one shared digit-serial 32x32 multiplier. Each product is issued,
// worked through in sixteen four-bit digit steps, presented and then summed.
// The next sample is taken only once the item is closed and the result has left
// the output register, so the input waits while the result waits for its transfer.
// Configuration writes land directly in the coefficient registers and must be
// done while idle. Every one of the eight index values names a register.
module sogi_single_phase_pll_core
    import spll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    spll_in_if.sink     in_ch,
    spll_out_if.source  out_ch
);
`include "sogi_single_phase_pll_core_defines.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_SUM = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // multiply job numbers
    localparam logic [3:0] J_IP0 = 4'd0;
    localparam logic [3:0] J_IP1 = 4'd1;
    localparam logic [3:0] J_IP2 = 4'd2;
    localparam logic [3:0] J_QD0 = 4'd3;
    localparam logic [3:0] J_QD1 = 4'd4;
    localparam logic [3:0] J_QD2 = 4'd5;
    localparam logic [3:0] J_CI = 4'd6;
    localparam logic [3:0] J_SQ = 4'd7;
    localparam logic [3:0] J_CQ = 4'd8;
    localparam logic [3:0] J_SI = 4'd9;
    localparam logic [3:0] J_LN = 4'd10;
    localparam logic [3:0] J_LP = 4'd11;
    localparam logic [3:0] J_INC = 4'd12;
    localparam logic [3:0] J_LAST = 4'd12;

    // configuration registers
    logic signed [31:0] direct_reg, fb1_reg, fb2_reg, quad_reg, lgn_reg, lgp_reg;
    logic [30:0]        nominal_reg;
    logic [31:0]        step_reg;

    // filter and loop state
    logic signed [15:0] u1_reg, u2_reg;
    logic signed [31:0] ip1_reg, ip2_reg, qd1_reg, qd2_reg;
    logic signed [31:0] integ_reg, perr_reg;
    logic [31:0]        phase_reg;
    logic signed [15:0] sin_reg, cos_reg;

    // per-item working registers
    logic signed [15:0] u0_reg;
    logic signed [35:0] sum_reg, sum_next;
    logic signed [31:0] ip_reg, qd_reg, uq_reg, ud_reg, freq_reg;
    logic [2:0]         state_reg, state_next;
    logic [3:0]         job_reg;

    // output register
    logic               ovalid_reg;
    logic signed [31:0] o_freq_reg, o_q_reg, o_d_reg;
    logic [31:0]        o_phase_reg;
    logic signed [15:0] o_sin_reg, o_cos_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    spll_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    logic signed [63:0] prod;
    logic signed [35:0] term;
    logic signed [31:0] sat_sum;
    logic signed [17:0] udiff, usum;
    logic [31:0]        step_fix;
    logic [31:0]        new_phase;
    logic [PHASE_TABLE_BITS-1:0] tidx;

    assign prod = $signed(mrsp.prod);
    assign sat_sum = sat32(sum_reg);
    assign udiff = 18'(u0_reg) - 18'(u2_reg);
    assign usum = 18'(u0_reg) + (18'(u1_reg) <<< 1) + 18'(u2_reg);
    // the multiplier takes the phase step as signed; with its top bit set the
    // product is short by frequency * 2^32, which lands in bits 47:16
    assign step_fix = step_reg[31] ? {freq_reg[15:0], 16'h0000} : 32'h00000000;
    assign new_phase = phase_reg + prod[47:16] + step_fix;
    assign tidx = new_phase[31 -: PHASE_TABLE_BITS];

    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mreq.start = (state_reg == ST_ISSUE);
        mreq.a = '0;
        mreq.b = '0;
        case (job_reg)
            J_IP0: begin mreq.a = direct_reg; mreq.b = 32'(udiff); end
            J_IP1: begin mreq.a = fb1_reg; mreq.b = ip1_reg; end
            J_IP2: begin mreq.a = fb2_reg; mreq.b = ip2_reg; end
            J_QD0: begin mreq.a = quad_reg; mreq.b = 32'(usum); end
            J_QD1: begin mreq.a = fb1_reg; mreq.b = qd1_reg; end
            J_QD2: begin mreq.a = fb2_reg; mreq.b = qd2_reg; end
            J_CI:  begin mreq.a = 32'(cos_reg); mreq.b = ip_reg; end
            J_SQ:  begin mreq.a = 32'(sin_reg); mreq.b = qd_reg; end
            J_CQ:  begin mreq.a = 32'(cos_reg); mreq.b = qd_reg; end
            J_SI:  begin mreq.a = 32'(sin_reg); mreq.b = ip_reg; end
            J_LN:  begin mreq.a = lgn_reg; mreq.b = uq_reg; end
            J_LP:  begin mreq.a = lgp_reg; mreq.b = perr_reg; end
            J_INC: begin mreq.a = freq_reg; mreq.b = step_reg; end
            default: begin mreq.a = '0; mreq.b = '0; end
        endcase
    end

    // scale each product to its target format (floor by arithmetic shift)
    always_comb
    begin
        case (job_reg)
            J_IP0, J_QD0: term = 36'(prod >>> 16);
            J_IP1, J_IP2, J_QD1, J_QD2: term = 36'(prod >>> 30);
            J_CI, J_SQ, J_CQ, J_SI: term = 36'(prod >>> 15);
            J_LN, J_LP: term = 36'(prod >>> 29);
            default: term = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next = sum_reg;
        case (state_reg)
            ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = ST_ISSUE;
                    sum_next = '0;
                end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
                if (mrsp.done)
                begin
                    // Park d uses cos*q minus sin*i
                    if (job_reg == J_SI)
                        sum_next = sum_reg - term;
                    else
                        sum_next = sum_reg + term;
                    state_next = ST_SUM;
                end
            ST_SUM:
            begin
                state_next = (job_reg == J_LAST) ? ST_DONE : ST_ISSUE;
                // start the next sum: empty, or from the loop integrator
                case (job_reg)
                    J_IP2, J_QD2, J_SQ: sum_next = '0;
                    J_SI: sum_next = 36'(integ_reg);
                    default: ;
                endcase
            end
            ST_DONE:
                state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg <= J_IP0;
            ovalid_reg <= 1'b0;
            direct_reg <= 32'sd4199880;
            fb1_reg <= 32'sd2138820699;
            fb2_reg <= -32'sd1065343016;
            quad_reg <= 32'sd32985;
            lgn_reg <= 32'sd10942831;
            lgp_reg <= -32'sd10896408;
            nominal_reg <= 31'd3276800;
            step_reg <= 32'd214748;
            u1_reg <= '0;
            u2_reg <= '0;
            ip1_reg <= '0;
            ip2_reg <= '0;
            qd1_reg <= '0;
            qd2_reg <= '0;
            integ_reg <= '0;
            perr_reg <= '0;
            phase_reg <= '0;
            sin_reg <= '0;
            cos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIRECT: direct_reg <= cfg_data;
                    REG_FB1: fb1_reg <= cfg_data;
                    REG_FB2: fb2_reg <= cfg_data;
                    REG_QUAD: quad_reg <= cfg_data;
                    REG_LG_NOW: lgn_reg <= cfg_data;
                    REG_LG_PRIOR: lgp_reg <= cfg_data;
                    REG_NOMINAL: nominal_reg <= cfg_data[30:0];
                    REG_STEP: step_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_IDLE)
                job_reg <= J_IP0;
            if (state_reg == ST_SUM)
            begin
                job_reg <= job_reg + 1'b1;
                // hold the new loop integrator value
                if (job_reg == J_LP)
                    integ_reg <= sat_sum;
            end
            if (state_reg == ST_WAIT && mrsp.done && job_reg == J_INC)
            begin
                // close the item: advance history and phase, latch the result
                phase_reg <= new_phase;
                sin_reg <= table_sine(tidx);
                cos_reg <= table_sine(tidx + PHASE_TABLE_BITS'(QUARTER_SIZE));
                u2_reg <= u1_reg;
                u1_reg <= u0_reg;
                ip2_reg <= ip1_reg;
                ip1_reg <= ip_reg;
                qd2_reg <= qd1_reg;
                qd1_reg <= qd_reg;
                perr_reg <= uq_reg;
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (in_ch.valid && in_ch.ready)
            u0_reg <= in_ch.sample;
        if (state_reg == ST_SUM)
        begin
            case (job_reg)
                J_IP2: ip_reg <= sat_sum;
                J_QD2: qd_reg <= sat_sum;
                J_SQ:  uq_reg <= sat_sum;
                J_SI:  ud_reg <= sat_sum;
                J_LP:  freq_reg <= sat32(36'(nominal_reg) + 36'(sat_sum));
                default: ;
            endcase
        end
        if (state_reg == ST_WAIT && mrsp.done && job_reg == J_INC)
        begin
            o_freq_reg <= freq_reg;
            o_phase_reg <= new_phase;
            o_sin_reg <= table_sine(tidx);
            o_cos_reg <= table_sine(tidx + PHASE_TABLE_BITS'(QUARTER_SIZE));
            o_q_reg <= uq_reg;
            o_d_reg <= ud_reg;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.frequency = o_freq_reg;
    assign out_ch.phase_angle = o_phase_reg;
    assign out_ch.sine_out = o_sin_reg;
    assign out_ch.cosine_out = o_cos_reg;
    assign out_ch.q_error = o_q_reg;
    assign out_ch.d_component = o_d_reg;

    `SPLL_ASSERT(a_no_take_while_busy, !(in_ch.ready && state_reg != ST_IDLE),
        "input taken while an item is in work")
    `SPLL_ASSERT_NEXT(a_start_then_wait, state_reg == ST_ISSUE, state_reg == ST_WAIT,
        "multiplier start not followed by wait")
    `SPLL_ASSERT(a_done_only_in_wait, !(mrsp.done && state_reg != ST_WAIT),
        "multiplier finished outside wait state")
endmodule
